// ----- sv/obstacle_avoid_drive_fsm_top_macros.svh -----
// Assertion macros for the drive controller checker
`ifndef OBSTACLE_AVOID_DRIVE_FSM_TOP_MACROS_SVH
`define OBSTACLE_AVOID_DRIVE_FSM_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define OAD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define OAD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/oad_pkg.sv -----
// ----------------------------------------------------------------------------
// oad_pkg
// Shared types and constants of the obstacle avoidance drive controller.
// ----------------------------------------------------------------------------
package oad_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] REG_PIVOT  = 3'd0;
   localparam logic [2:0] REG_ARC    = 3'd1;
   localparam logic [2:0] REG_CLEAR  = 3'd2;
   localparam logic [2:0] REG_CLOSE  = 3'd3;
   localparam logic [2:0] REG_PTURN  = 3'd4;
   localparam logic [2:0] REG_AMIN   = 3'd5;
   localparam logic [2:0] REG_AMAX   = 3'd6;
   localparam logic [2:0] REG_DECIDE = 3'd7;

   localparam logic [8:0]  PIVOT_RST  = 9'd64;
   localparam logic [8:0]  ARC_RST    = 9'd79;
   localparam logic [8:0]  CLEAR_RST  = 9'd75;
   localparam logic [8:0]  CLOSE_RST  = 9'd12;
   localparam logic [15:0] PTURN_RST  = 16'd350;
   localparam logic [15:0] AMIN_RST   = 16'd300;
   localparam logic [15:0] AMAX_RST   = 16'd900;
   localparam logic [15:0] DECIDE_RST = 16'd30;

   localparam logic [31:0] STARTUP_MS      = 32'd1500;
   localparam logic [31:0] CHAIN_DECIDE_MS = 32'd16;
   localparam logic [31:0] CHAIN_HOLD_MS   = 32'd70;
   localparam logic [31:0] BUMP_CHAIN_MS   = 32'd180;
   localparam logic [31:0] BUMP_MS         = 32'd240;
   localparam logic [31:0] DRIVE_HOLD_MS   = 32'd150;
   localparam logic [31:0] TURN_HOLD_MS    = 32'd130;
   localparam logic [31:0] CHAIN_MS        = 32'd350;
   localparam logic [31:0] BUMP_COOL_MS    = 32'd120;
   localparam logic [31:0] SHARP_ARC_MS    = 32'd240;
   localparam logic [31:0] SPEED_FAST_MS   = 32'd140;
   localparam logic [31:0] SPEED_SLOW_MS   = 32'd100;
   localparam logic [8:0]  SLOW_BELOW_CM   = 9'd62;
   localparam logic [8:0]  SPEEDUP_FROM_CM = 9'd68;
   localparam logic [8:0]  OUTER_OPEN_CM   = 9'd82;
   localparam logic [8:0]  OUTER_MAX_CM    = 9'd300;
   localparam logic [8:0]  BUMP_LO_CM      = 9'd45;
   localparam logic [8:0]  BUMP_HI_CM      = 9'd85;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_START  = 1'b1;

   typedef enum logic [2:0] {
      CMD_FORWARD     = 3'd0,
      CMD_PIVOT_LEFT  = 3'd1,
      CMD_PIVOT_RIGHT = 3'd2,
      CMD_SLOW        = 3'd3,
      CMD_SPEED_UP    = 3'd4,
      CMD_LEFT_SLOW   = 3'd5,
      CMD_RIGHT_SLOW  = 3'd6
   } cmd_type;

   // one accepted update: up to four commands, last_idx = count - 1
   typedef struct packed {
      logic [1:0]       last_idx;
      logic [3:0][2:0]  cmds;
   } batch_type;

endpackage

// ----- sv/oad_front.sv -----
// ----------------------------------------------------------------------------
// oad_front
// Accepts requests, keeps the controller state and builds the command batch.
// ----------------------------------------------------------------------------
module oad_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               req_tuser,
   input  logic [63:0]        req_tdata,
   input  logic               csr_valid,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  logic               queue_full,
   output logic               push,
   output oad_pkg::batch_type push_batch
);
   import oad_pkg::*;

   logic [8:0]  pivot_ff, arc_ff, clear_ff, close_ff;
   logic [15:0] pturn_ff, amin_ff, amax_ff, decide_ff;

   logic turning_ff, turning_in, arc_mode_ff, arc_mode_in, right_ff, right_in;
   logic in_bump_ff, in_bump_in;
   logic signed [2:0] vote_ff, vote_in;
   logic [31:0] deadline_ff, deadline_in, next_dec_ff, next_dec_in, hold_ff, hold_in;
   logic [31:0] startup_ff, startup_in, lte_ff, lte_in, chain_ff, chain_in;
   logic [31:0] bump_ff, bump_in, cool_ff, cool_in, bias_ff, bias_in;
   logic [8:0]  prev_ff, prev_in;
   logic signed [9:0] delta_ff [3];
   logic signed [9:0] delta_in [3];
   logic [1:0]  slot_ff, slot_in, warm_ff, warm_in, phase_ff, phase_in;
   logic [7:0]  close_st_ff, close_st_in, open_st_ff, open_st_in;

   logic [31:0] now;
   logic [8:0]  lcm, ccm, rcm;

   assign now = req_tdata[31:0];
   assign lcm = req_tdata[40:32];
   assign ccm = req_tdata[49:41];
   assign rcm = req_tdata[58:50];
   assign req_tready = !queue_full && !reset;

   function automatic logic signed [2:0] vote_step(input logic signed [2:0] v,
                                                   input logic [8:0] l, input logic [8:0] r);
      logic signed [2:0] t;
      t = v;
      if (r > l) begin
         if (t < 3'sd2) t = t + 3'sd1;
      end else begin
         if (t > -3'sd2) t = t - 3'sd1;
      end
      return t;
   endfunction

   always_comb begin
      logic [2:0] n;
      logic [3:0][2:0] cmds;
      logic signed [9:0] d_new, older;
      logic signed [11:0] sum;
      logic ready, av_le_m3, av_ge_3, av_ge_4, av_abs2, av_abs1;
      logic chaining, dec_due, fast_open, dir_right, sharp_u, soft_l, pivot_ok;
      logic [31:0] dec, drv_hold, dlt, past;
      logic [8:0] nearer, min_all, far_side, lr_abs;
      logic [9:0] pth, ath, cth;
      logic signed [16:0] lim;
      logic do_end;

      turning_in = turning_ff; arc_mode_in = arc_mode_ff; right_in = right_ff;
      in_bump_in = in_bump_ff; vote_in = vote_ff; deadline_in = deadline_ff;
      next_dec_in = next_dec_ff; hold_in = hold_ff; startup_in = startup_ff;
      lte_in = lte_ff; chain_in = chain_ff; bump_in = bump_ff; cool_in = cool_ff;
      bias_in = bias_ff; prev_in = prev_ff; slot_in = slot_ff; warm_in = warm_ff;
      phase_in = phase_ff; close_st_in = close_st_ff; open_st_in = open_st_ff;
      delta_in = delta_ff;
      n = 3'd0; cmds = '0; push = 1'b0; do_end = 1'b0;
      d_new = '0; older = '0; sum = '0; ready = 1'b0;
      av_le_m3 = 1'b0; av_ge_3 = 1'b0; av_ge_4 = 1'b0; av_abs2 = 1'b0; av_abs1 = 1'b0;
      chaining = 1'b0; dec_due = 1'b0; fast_open = 1'b0; dir_right = 1'b0;
      sharp_u = 1'b0; soft_l = 1'b0; pivot_ok = 1'b0;
      dec = '0; drv_hold = '0; dlt = '0; past = '0;
      nearer = '0; min_all = '0; far_side = '0; lr_abs = '0;
      pth = '0; ath = '0; cth = '0; lim = '0;

      if (req_tvalid && req_tready && req_tuser == OP_START) begin
         startup_in = now + STARTUP_MS;
         vote_in = '0;
         turning_in = 1'b0;
         prev_in = ccm;
         delta_in[0] = '0; delta_in[1] = '0; delta_in[2] = '0;
         slot_in = '0; warm_in = '0; close_st_in = '0; open_st_in = '0;
         lte_in = now; chain_in = now; bump_in = now; cool_in = now;
         in_bump_in = 1'b0;
         bias_in = '0;
         phase_in = '0;
      end else if (req_tvalid && req_tready) begin
         push = 1'b1;
         d_new = $signed({1'b0, ccm}) - $signed({1'b0, prev_ff});
         delta_in[slot_ff] = d_new;
         prev_in = ccm;
         slot_in = (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
         if (warm_ff != 2'd3) warm_in = warm_ff + 2'd1;
         older = delta_ff[(slot_ff == 2'd0) ? 2'd2 : slot_ff - 2'd1];
         sum = 12'(delta_in[0]) + 12'(delta_in[1]) + 12'(delta_in[2]);
         ready = (warm_in == 2'd3);
         av_le_m3 = sum <= -12'sd9;
         av_ge_3  = sum >= 12'sd9;
         av_ge_4  = sum >= 12'sd12;
         av_abs2  = (sum >= -12'sd8) && (sum <= 12'sd8);
         av_abs1  = (sum >= -12'sd5) && (sum <= 12'sd5);
         if (ready && av_le_m3) begin
            if (close_st_ff != 8'd255) close_st_in = close_st_ff + 8'd1;
         end else begin
            close_st_in = '0;
         end
         if (ready && av_ge_3) begin
            if (open_st_ff != 8'd255) open_st_in = open_st_ff + 8'd1;
         end else begin
            open_st_in = '0;
         end

         dlt = now - startup_ff;
         if (dlt[31]) begin
            cmds[n[1:0]] = CMD_FORWARD; n = n + 3'd1;
            cmds[n[1:0]] = CMD_SLOW;    n = n + 3'd1;
         end else if (ccm <= close_ff) begin
            vote_in = vote_step(vote_ff, lcm, rcm);
            right_in = (vote_in >= 3'sd0);
            turning_in = 1'b1; arc_mode_in = 1'b0;
            deadline_in = now + 32'(pturn_ff);
            hold_in = now + TURN_HOLD_MS;
            in_bump_in = 1'b0;
            cmds[n[1:0]] = CMD_SLOW; n = n + 3'd1;
            cmds[n[1:0]] = right_in ? CMD_PIVOT_RIGHT : CMD_PIVOT_LEFT; n = n + 3'd1;
         end else begin
            dlt = now - chain_ff;
            chaining = dlt[31];
            dec = chaining ? CHAIN_DECIDE_MS : 32'(decide_ff);
            drv_hold = chaining ? CHAIN_HOLD_MS : DRIVE_HOLD_MS;
            dlt = now - next_dec_ff;
            dec_due = !dlt[31];
            if (dec_due) next_dec_in = now + dec;

            dlt = now - lte_ff;
            if (!in_bump_ff && (dlt[31] || dlt <= CHAIN_MS) && ready) begin
               if (av_abs2 && ((d_new > 0 && older < 0) || (d_new < 0 && older > 0))
                   && ccm >= BUMP_LO_CM && ccm <= BUMP_HI_CM) begin
                  in_bump_in = 1'b1;
                  bump_in = now + (chaining ? BUMP_CHAIN_MS : BUMP_MS);
               end
            end

            if (in_bump_in) begin
               cmds[n[1:0]] = CMD_FORWARD;  n = n + 3'd1;
               cmds[n[1:0]] = CMD_SPEED_UP; n = n + 3'd1;
               dlt = now - cool_ff;
               if (!dlt[31]) cool_in = now + BUMP_COOL_MS;
               dlt = now - bump_in;
               if (!dlt[31] || (ready && av_abs1)) in_bump_in = 1'b0;
            end else if (!turning_ff) begin
               nearer = (lcm < rcm) ? lcm : rcm;
               min_all = (nearer < ccm) ? nearer : ccm;
               fast_open = ready && av_ge_3 && open_st_in >= 8'd2;
               lr_abs = (lcm > rcm) ? lcm - rcm : rcm - lcm;
               cmds[n[1:0]] = CMD_FORWARD; n = n + 3'd1;
               dlt = now - cool_ff;
               if (min_all < SLOW_BELOW_CM) begin
                  cmds[n[1:0]] = CMD_SLOW; n = n + 3'd1;
               end else if (!dlt[31] && min_all >= SPEEDUP_FROM_CM) begin
                  cmds[n[1:0]] = CMD_SPEED_UP; n = n + 3'd1;
                  cool_in = now + (fast_open ? SPEED_FAST_MS : SPEED_SLOW_MS);
               end
               if (dec_due) vote_in = vote_step(vote_ff, lcm, rcm);
               dir_right = (vote_in >= 3'sd0);
               sharp_u = ready && av_le_m3 && close_st_in >= 8'd2 && lr_abs <= 9'd10;
               soft_l = lr_abs >= 9'd20 && !(ready && av_le_m3);
               dlt = now - hold_ff;
               if (dec_due && !dlt[31]) begin
                  pth = {1'b0, pivot_ff};
                  ath = {1'b0, arc_ff};
                  if (ready) begin
                     if (close_st_in >= 8'd2) begin
                        pth = pth + 10'd4; ath = ath + 10'd3;
                     end else if (open_st_in >= 8'd2 && ath > 10'd3) begin
                        ath = ath - 10'd3;
                     end
                  end
                  if (chaining && pth >= 10'd2) pth = pth - 10'd2;
                  pth = (pth < 10'd40) ? 10'd40 : ((pth > 10'd90) ? 10'd90 : pth);
                  ath = (ath < 10'd55) ? 10'd55 : ((ath > 10'd95) ? 10'd95 : ath);
                  pivot_ok = !soft_l || ({1'b0, ccm} <= pth - 10'd4);
                  if ({1'b0, ccm} <= pth && pivot_ok) begin
                     turning_in = 1'b1; arc_mode_in = 1'b0; right_in = dir_right;
                     deadline_in = now + 32'(pturn_ff);
                     hold_in = now + TURN_HOLD_MS;
                     cmds[n[1:0]] = CMD_SLOW; n = n + 3'd1;
                     cmds[n[1:0]] = dir_right ? CMD_PIVOT_RIGHT : CMD_PIVOT_LEFT;
                     n = n + 3'd1;
                  end else if ({1'b0, ccm} <= ath) begin
                     turning_in = 1'b1; arc_mode_in = 1'b1; right_in = dir_right;
                     deadline_in = now + (sharp_u ? SHARP_ARC_MS : 32'(amin_ff));
                     hold_in = now + TURN_HOLD_MS;
                     phase_in = soft_l ? 2'd1 : 2'd0;
                     bias_in = '0;
                     cmds[n[1:0]] = CMD_SLOW;    n = n + 3'd1;
                     cmds[n[1:0]] = CMD_FORWARD; n = n + 3'd1;
                  end
               end
            end else if (!arc_mode_ff) begin
               dlt = deadline_ff - now;
               do_end = (dlt == '0) || dlt[31];
            end else begin
               past = now - deadline_ff;
               lim = $signed({1'b0, amax_ff}) - $signed({1'b0, amin_ff});
               far_side = right_ff ? lcm : rcm;
               cth = {1'b0, clear_ff} + 10'd2;
               if (ready && open_st_in >= 8'd2 && cth > 10'd2) cth = cth - 10'd2;
               cth = (cth < 10'd50) ? 10'd50 : ((cth > 10'd90) ? 10'd90 : cth);
               if ((!past[31] && ready && av_ge_4 && open_st_in >= 8'd3
                    && far_side >= OUTER_OPEN_CM && far_side <= OUTER_MAX_CM)
                   || ({1'b0, ccm} >= cth && !past[31])
                   || ($signed(past) >= 32'(lim))) begin
                  do_end = 1'b1;
               end else begin
                  cmds[n[1:0]] = CMD_FORWARD; n = n + 3'd1;
                  dlt = now - bias_ff;
                  if (!dlt[31]) begin
                     if (phase_ff <= 2'd2) begin
                        cmds[n[1:0]] = right_ff ? CMD_RIGHT_SLOW : CMD_LEFT_SLOW;
                        n = n + 3'd1;
                     end
                     bias_in = now + 32'(decide_ff);
                     if (phase_ff != 2'd3) phase_in = phase_ff + 2'd1;
                  end
               end
            end
            if (do_end) begin
               turning_in = 1'b0;
               hold_in = now + drv_hold;
               cmds[n[1:0]] = CMD_FORWARD; n = n + 3'd1;
               cmds[n[1:0]] = CMD_SLOW;    n = n + 3'd1;
               lte_in = now;
               chain_in = now + CHAIN_MS;
               phase_in = '0;
            end
         end
         if (n == 3'd0) push = 1'b0;
      end
      push_batch.cmds = cmds;
      push_batch.last_idx = 2'(n - 3'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_ff <= PIVOT_RST; arc_ff <= ARC_RST; clear_ff <= CLEAR_RST;
         close_ff <= CLOSE_RST; pturn_ff <= PTURN_RST; amin_ff <= AMIN_RST;
         amax_ff <= AMAX_RST; decide_ff <= DECIDE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_PIVOT:  pivot_ff  <= csr_data[8:0];
            REG_ARC:    arc_ff    <= csr_data[8:0];
            REG_CLEAR:  clear_ff  <= csr_data[8:0];
            REG_CLOSE:  close_ff  <= csr_data[8:0];
            REG_PTURN:  pturn_ff  <= csr_data;
            REG_AMIN:   amin_ff   <= csr_data;
            REG_AMAX:   amax_ff   <= csr_data;
            REG_DECIDE: decide_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         turning_ff <= 1'b0; arc_mode_ff <= 1'b0; right_ff <= 1'b0; in_bump_ff <= 1'b0;
         vote_ff <= '0; deadline_ff <= '0; next_dec_ff <= '0; hold_ff <= '0;
         startup_ff <= '0; lte_ff <= '0; chain_ff <= '0; bump_ff <= '0; cool_ff <= '0;
         bias_ff <= '0; prev_ff <= '0; slot_ff <= '0; warm_ff <= '0; phase_ff <= '0;
         close_st_ff <= '0; open_st_ff <= '0;
         delta_ff[0] <= '0; delta_ff[1] <= '0; delta_ff[2] <= '0;
      end else begin
         turning_ff <= turning_in; arc_mode_ff <= arc_mode_in; right_ff <= right_in;
         in_bump_ff <= in_bump_in; vote_ff <= vote_in; deadline_ff <= deadline_in;
         next_dec_ff <= next_dec_in; hold_ff <= hold_in; startup_ff <= startup_in;
         lte_ff <= lte_in; chain_ff <= chain_in; bump_ff <= bump_in; cool_ff <= cool_in;
         bias_ff <= bias_in; prev_ff <= prev_in; slot_ff <= slot_in; warm_ff <= warm_in;
         phase_ff <= phase_in; close_st_ff <= close_st_in; open_st_ff <= open_st_in;
         delta_ff <= delta_in;
      end
   end

endmodule

// ----- sv/oad_queue.sv -----
// ----------------------------------------------------------------------------
// oad_queue
// Small FIFO of command batches between the front and the back.
// ----------------------------------------------------------------------------
module oad_queue #(
   parameter int DEPTH = oad_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  oad_pkg::batch_type push_batch,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output oad_pkg::batch_type head
);
   import oad_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   batch_type       store_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == CW'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = store_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ff] <= push_batch;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- sv/oad_back.sv -----
// ----------------------------------------------------------------------------
// oad_back
// Drains the head batch one command per cycle, while rsp_tready is high.
// ----------------------------------------------------------------------------
module oad_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  oad_pkg::batch_type head,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast
);
   import oad_pkg::*;

   logic [1:0] idx_ff, idx_in;

   assign rsp_tvalid = !empty;
   assign rsp_tdata  = {5'd0, head.cmds[idx_ff]};
   assign rsp_tlast  = (idx_ff == head.last_idx);
   assign pop        = rsp_tvalid && rsp_tready && rsp_tlast;

   always_comb begin
      idx_in = idx_ff;
      if (rsp_tvalid && rsp_tready) idx_in = rsp_tlast ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else idx_ff <= idx_in;
   end

endmodule

// ----- sv/obstacle_avoid_drive_fsm_top.sv -----
// An accepted request's commands are written to the batch queue, then offered
// from its head. One request per cycle enters while the queue is not full; commands
// leave one per cycle while rsp_tready is high, and an item produces 0..4 commands.
// The queue holds QUEUE_DEPTH batches; start requests produce no commands.
// Reset: synchronous active-high; clears state, queue and restores register defaults.
// ----------------------------------------------------------------------------
// obstacle_avoid_drive_fsm_top
// Three-sensor obstacle avoidance controller emitting actuator commands.
// ----------------------------------------------------------------------------
module obstacle_avoid_drive_fsm_top #(
   parameter int QUEUE_DEPTH = oad_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // now_ms, left_cm, center_cm, right_cm
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // command
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import oad_pkg::*;

   logic      push, pop, full, empty;
   batch_type push_batch, head;

   assign csr_ready = !reset;

   oad_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tuser, .req_tdata,
      .csr_valid, .csr_index, .csr_data,
      .queue_full(full), .push, .push_batch
   );

   oad_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset, .push, .push_batch, .pop, .full, .empty, .head
   );

   oad_back u_back (
      .clock, .reset, .empty, .head, .pop,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

endmodule

// ----- sv/oad_checker.sv -----
// ----------------------------------------------------------------------------
// oad_checker
// Port-level checks of the drive controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "obstacle_avoid_drive_fsm_top_macros.svh"

module oad_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_ready
);

   `OAD_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[7:3] == 5'd0, "pad bits set")
   `OAD_ASSERT_NOW(a_cmd_range, clock, reset, rsp_tvalid, rsp_tdata[2:0] != 3'd7, "bad command")
   `OAD_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled response changed")
   `OAD_ASSERT_NOW(a_csr_ready, clock, reset, 1'b1, csr_ready, "config port not ready")

endmodule

bind obstacle_avoid_drive_fsm_top oad_checker u_oad_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .csr_ready
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the obstacle avoidance drive controller. Sends start
// and update requests built as short drives toward obstacles, predicts the
// actuator commands of each accepted request and compares every command and
// its last flag in order, over several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb;
   import oad_pkg::*;

   typedef struct {
      cmd_type cmd;
      bit      last;
   } drive_cmd_t;

   class cmd_scoreboard;
      drive_cmd_t pending[$];
      int         errors;

      function void note(drive_cmd_t c);
         pending.push_back(c);
      endfunction

      function void check(logic [2:0] cmd, logic last);
         drive_cmd_t e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected command %0d last %0b", cmd, last);
            return;
         end
         e = pending.pop_front();
         if (cmd !== e.cmd || last !== e.last) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected cmd %0d last %0b, got cmd %0d last %0b",
                        e.cmd, e.last, cmd, last);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   obstacle_avoid_drive_fsm_top DUT (.*);

   cmd_scoreboard sb = new();
   int idle_pct;
   int stall_pct;

   // predictor state
   logic [15:0] cfg [8];
   bit          turning, arc_turn, turn_rt, in_bump;
   int          vote_acc;
   logic [31:0] turn_dl, next_dec, hold_t, startup_t, last_end, chain_t, bump_t, cool_t, bias_t;
   int          prev_c;
   int          deltas [3];
   int          slot, warm, close_st, open_st, phase_a;
   logic [31:0] now_t;
   int          cen, lft, rgt;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int sd(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return $signed(d);
   endfunction

   function automatic int iab(int v);
      return v < 0 ? -v : v;
   endfunction

   function automatic int clampi(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   task automatic do_vote(int l, int r);
      vote_acc += (r > l) ? 1 : -1;
      vote_acc = clampi(vote_acc, -2, 2);
   endtask

   task automatic model_reset();
      cfg[REG_PIVOT] = PIVOT_RST;   cfg[REG_ARC] = ARC_RST;
      cfg[REG_CLEAR] = CLEAR_RST;   cfg[REG_CLOSE] = CLOSE_RST;
      cfg[REG_PTURN] = PTURN_RST;   cfg[REG_AMIN] = AMIN_RST;
      cfg[REG_AMAX] = AMAX_RST;     cfg[REG_DECIDE] = DECIDE_RST;
      turning = 0; arc_turn = 0; turn_rt = 0; in_bump = 0; vote_acc = 0;
      turn_dl = 0; next_dec = 0; hold_t = 0; startup_t = 0; last_end = 0;
      chain_t = 0; bump_t = 0; cool_t = 0; bias_t = 0; prev_c = 0;
      deltas = '{0, 0, 0};
      slot = 0; warm = 0; close_st = 0; open_st = 0; phase_a = 0;
   endtask

   task automatic predict_cmds(bit op, logic [31:0] now, int l, int c, int r);
      cmd_type     q[$];
      drive_cmd_t  e;
      int          avg, newest, older, lr_abs, nearer, min_all, pth, ath, cth, far_side, past;
      bit          rdy, chaining, can_dec, fast_open, dir_rt, sharp_u, soft_l, allow_pv;
      bit          min_done, too_long, ctr_clear, side_clear;
      logic [31:0] drv_hold, dec, d;
      if (op == OP_START) begin
         startup_t = now + STARTUP_MS;
         vote_acc = 0; turning = 0; prev_c = c;
         deltas = '{0, 0, 0};
         slot = 0; warm = 0; close_st = 0; open_st = 0;
         last_end = now; chain_t = now; bump_t = now; cool_t = now;
         in_bump = 0; bias_t = 0; phase_a = 0;
         return;
      end
      deltas[slot] = c - prev_c;
      prev_c = c;
      slot = (slot + 1) % 3;
      if (warm < 3) warm++;
      avg = (deltas[0] + deltas[1] + deltas[2]) / 3;
      rdy = warm >= 3;
      if (rdy && avg <= -3) begin
         if (close_st < 255) close_st++;
      end else close_st = 0;
      if (rdy && avg >= 3) begin
         if (open_st < 255) open_st++;
      end else open_st = 0;

      if (sd(now, startup_t) < 0) begin
         q.push_back(CMD_FORWARD); q.push_back(CMD_SLOW);
      end else if (c <= cfg[REG_CLOSE]) begin
         do_vote(l, r);
         turn_rt = vote_acc >= 0;
         turning = 1; arc_turn = 0;
         turn_dl = now + cfg[REG_PTURN];
         hold_t = now + TURN_HOLD_MS;
         in_bump = 0;
         q.push_back(CMD_SLOW);
         q.push_back(turn_rt ? CMD_PIVOT_RIGHT : CMD_PIVOT_LEFT);
      end else begin
         chaining = sd(now, chain_t) < 0;
         dec = chaining ? CHAIN_DECIDE_MS : 32'(cfg[REG_DECIDE]);
         drv_hold = chaining ? CHAIN_HOLD_MS : DRIVE_HOLD_MS;
         can_dec = sd(now, next_dec) >= 0;
         if (can_dec) next_dec = now + dec;
         if (!in_bump && sd(now, last_end) <= 350 && rdy) begin
            newest = deltas[(slot + 2) % 3];
            older = deltas[(slot + 1) % 3];
            if (iab(avg) <= 2 && ((newest > 0 && older < 0) || (newest < 0 && older > 0))
                && c >= 45 && c <= 85) begin
               in_bump = 1;
               bump_t = now + (chaining ? BUMP_CHAIN_MS : BUMP_MS);
            end
         end
         if (in_bump) begin
            q.push_back(CMD_FORWARD); q.push_back(CMD_SPEED_UP);
            if (sd(now, cool_t) >= 0) cool_t = now + BUMP_COOL_MS;
            if (sd(now, bump_t) >= 0 || (rdy && iab(avg) <= 1)) in_bump = 0;
         end else if (!turning) begin
            nearer = l < r ? l : r;
            min_all = nearer < c ? nearer : c;
            fast_open = rdy && avg >= 3 && open_st >= 2;
            lr_abs = iab(l - r);
            q.push_back(CMD_FORWARD);
            if (min_all < SLOW_BELOW_CM) q.push_back(CMD_SLOW);
            else if (sd(now, cool_t) >= 0 && min_all >= SPEEDUP_FROM_CM) begin
               q.push_back(CMD_SPEED_UP);
               cool_t = now + (fast_open ? SPEED_FAST_MS : SPEED_SLOW_MS);
            end
            if (can_dec) do_vote(l, r);
            dir_rt = vote_acc >= 0;
            sharp_u = rdy && avg <= -3 && close_st >= 2 && lr_abs <= 10;
            soft_l = lr_abs >= 20 && !(rdy && avg <= -3);
            if (can_dec && sd(now, hold_t) >= 0) begin
               pth = cfg[REG_PIVOT];
               ath = cfg[REG_ARC];
               if (rdy) begin
                  if (close_st >= 2) begin
                     pth += 4; ath += 3;
                  end else if (open_st >= 2 && ath > 3) ath -= 3;
               end
               if (chaining && pth >= 2) pth -= 2;
               pth = clampi(pth, 40, 90);
               ath = clampi(ath, 55, 95);
               allow_pv = !soft_l || c <= pth - 4;
               if (c <= pth && allow_pv) begin
                  turning = 1; arc_turn = 0; turn_rt = dir_rt;
                  turn_dl = now + cfg[REG_PTURN];
                  hold_t = now + TURN_HOLD_MS;
                  q.push_back(CMD_SLOW);
                  q.push_back(turn_rt ? CMD_PIVOT_RIGHT : CMD_PIVOT_LEFT);
               end else if (c <= ath) begin
                  turning = 1; arc_turn = 1; turn_rt = dir_rt;
                  turn_dl = now + (sharp_u ? SHARP_ARC_MS : 32'(cfg[REG_AMIN]));
                  hold_t = now + TURN_HOLD_MS;
                  phase_a = soft_l ? 1 : 0;
                  bias_t = 0;
                  q.push_back(CMD_SLOW); q.push_back(CMD_FORWARD);
               end
            end
         end else begin
            d = turn_dl - now;
            past = sd(now, turn_dl);
            if (arc_turn) begin
               min_done = past >= 0;
               too_long = longint'(past) >= longint'(cfg[REG_AMAX]) - longint'(cfg[REG_AMIN]);
               ctr_clear = rdy && avg >= 4 && open_st >= 3;
               far_side = turn_rt ? l : r;
               side_clear = far_side >= 2 && far_side <= 300 && far_side >= OUTER_OPEN_CM;
               cth = cfg[REG_CLEAR] + 2;
               if (rdy && open_st >= 2 && cth > 2) cth -= 2;
               cth = clampi(cth, 50, 90);
            end
            if (arc_turn ? ((min_done && ctr_clear && side_clear) || (c >= cth && min_done)
                            || too_long) : (d == 0 || d[31])) begin
               turning = 0;
               hold_t = now + drv_hold;
               q.push_back(CMD_FORWARD); q.push_back(CMD_SLOW);
               last_end = now;
               chain_t = now + CHAIN_MS;
               phase_a = 0;
            end else if (arc_turn) begin
               q.push_back(CMD_FORWARD);
               if (sd(now, bias_t) >= 0) begin
                  if (phase_a <= 2) q.push_back(turn_rt ? CMD_RIGHT_SLOW : CMD_LEFT_SLOW);
                  bias_t = now + cfg[REG_DECIDE];
                  if (phase_a < 3) phase_a++;
               end
            end
         end
      end
      foreach (q[i]) begin
         e.cmd = q[i];
         e.last = (i == q.size() - 1);
         sb.note(e);
      end
   endtask

   task automatic send_req(bit op, logic [31:0] now, int l, int c, int r);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {5'd0, r[8:0], c[8:0], l[8:0], now};
      do @(negedge clock); while (!req_tready);
      predict_cmds(op, now, l, c, r);
      @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(negedge clock); while (!csr_ready);
      cfg[idx] = (idx <= REG_CLOSE) ? {7'd0, val[8:0]} : val;
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // one item of a drive: time steps forward, distances drift with some noise, and now and then a start is sent
   task automatic drive_step(bit allow_noise);
      int step;
      step = ($urandom_range(19) == 0) ? $urandom_range(2000) : $urandom_range(60);
      now_t += step;
      if (allow_noise && $urandom_range(9) == 0) begin
         cen = $urandom_range(511); lft = $urandom_range(511); rgt = $urandom_range(511);
      end else begin
         cen = clampi(cen + $urandom_range(24) - 14, 0, 511);
         lft = clampi(lft + $urandom_range(30) - 15, 0, 511);
         rgt = clampi(rgt + $urandom_range(30) - 15, 0, 511);
      end
      if (allow_noise && $urandom_range(39) == 0)
         send_req(OP_START, now_t, lft, cen, rgt);
      else
         send_req(OP_UPDATE, now_t, lft, cen, rgt);
   endtask

   task automatic run_drives(int items);
      int n;
      n = 0;
      while (n < items) begin
         now_t = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(3000) : $urandom();
         cen = $urandom_range(60, 200);
         lft = $urandom_range(511);
         rgt = $urandom_range(511);
         send_req(OP_START, now_t, lft, cen, rgt);
         n++;
         if ($urandom_range(3) != 0) now_t += STARTUP_MS - $urandom_range(40);
         repeat ($urandom_range(10, 30)) begin
            drive_step(1'b1);
            n++;
         end
      end
   endtask

   task automatic directed();
      send_req(OP_UPDATE, 32'd5, 0, 511, 511);
      send_req(OP_UPDATE, 32'hFFFF_FFFF, 511, 0, 0);
      send_req(OP_START, 32'hFFFF_FF00, 100, 200, 100);
      send_req(OP_UPDATE, 32'hFFFF_FF10, 100, 200, 100);
      send_req(OP_UPDATE, 32'h0000_0600, 300, 100, 50);
      send_req(OP_UPDATE, 32'h0000_0620, 50, 100, 300);
      send_req(OP_UPDATE, 32'h0000_0640, 40, 10, 90);
      send_req(OP_UPDATE, 32'h0000_0660, 40, 100, 90);
      send_req(OP_UPDATE, 32'h0000_0800, 200, 150, 200);
      send_req(OP_UPDATE, 32'h0000_0900, 200, 76, 200);
      send_req(OP_UPDATE, 32'h0000_0920, 200, 78, 150);
      send_req(OP_UPDATE, 32'h0000_0960, 200, 79, 150);
      send_req(OP_UPDATE, 32'h0000_0A00, 100, 90, 100);
      send_req(OP_UPDATE, 32'h0000_0A20, 100, 95, 100);
      send_req(OP_UPDATE, 32'h0000_0A40, 100, 60, 100);
      send_req(OP_UPDATE, 32'h0000_0A60, 100, 66, 100);
      send_req(OP_UPDATE, 32'h0000_0A80, 100, 58, 100);
      send_req(OP_UPDATE, 32'h0000_0AA0, 100, 64, 100);
      send_req(OP_UPDATE, 32'h0000_0AC0, 511, 511, 511);
      send_req(OP_UPDATE, 32'h0000_0B00, 511, 511, 0);
      send_req(OP_START, 32'h8000_0000, 0, 0, 511);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      idle_pct = 0;
      stall_pct = 0;
      model_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed();
      run_drives(50);
      drain();

      idle_pct = 81;
      write_csr(REG_PIVOT, 16'd511);   write_csr(REG_ARC, 16'd511);
      write_csr(REG_CLEAR, 16'd511);   write_csr(REG_CLOSE, 16'd511);
      write_csr(REG_PTURN, 16'hFFFF);  write_csr(REG_AMIN, 16'hFFFF);
      write_csr(REG_AMAX, 16'hFFFF);   write_csr(REG_DECIDE, 16'hFFFF);
      run_drives(20);
      drain();
      write_csr(REG_CLOSE, 16'd0);
      run_drives(40);
      drain();

      idle_pct = 0;
      stall_pct = 81;
      write_csr(REG_PIVOT, 16'd0);     write_csr(REG_ARC, 16'd0);
      write_csr(REG_CLEAR, 16'd0);     write_csr(REG_CLOSE, 16'd0);
      write_csr(REG_PTURN, 16'd0);     write_csr(REG_AMIN, 16'd400);
      write_csr(REG_AMAX, 16'd0);      write_csr(REG_DECIDE, 16'd1);
      run_drives(60);
      drain();

      idle_pct = 26;
      stall_pct = 26;
      write_csr(REG_PIVOT, 16'($urandom_range(40, 90)));
      write_csr(REG_ARC, 16'($urandom_range(55, 95)));
      write_csr(REG_CLEAR, 16'($urandom_range(50, 90)));
      write_csr(REG_CLOSE, 16'($urandom_range(5, 30)));
      write_csr(REG_PTURN, 16'($urandom_range(100, 600)));
      write_csr(REG_AMIN, 16'($urandom_range(100, 500)));
      write_csr(REG_AMAX, 16'($urandom_range(400, 1200)));
      write_csr(REG_DECIDE, 16'($urandom_range(1, 80)));
      run_drives(70);
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata[2:0], rsp_tlast);
   end

endmodule
